/* rtl/core/hsv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hsv_pkg;

  // Default configuration
  localparam int PIXEL_BITS_DEF    = 8;
  localparam int HUE_FRAC_BITS_DEF = 4;
  localparam int SAT_FRAC_BITS_DEF = 8;

  // Hue geometry in whole degrees
  localparam int HUE_DEG_SEXTANT = 60;
  localparam int HUE_DEG_FULL    = 360;

  // Port field widths
  localparam int CHAN_W = 8;
  localparam int HUE_W  = 13;
  localparam int SAT_W  = 9;
  localparam int VAL_W  = 8;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue_out;
    logic [SAT_W-1:0] sat_out;
    logic [VAL_W-1:0] val_out;
  } hsv_out_t;

endpackage

`default_nettype wire

/* rtl/core/hsv_prep.sv */
`timescale 1ns / 1ps
`default_nettype none

module hsv_prep #(
  parameter int PIXEL_BITS    = hsv_pkg::PIXEL_BITS_DEF,
  parameter int HUE_FRAC_BITS = hsv_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = hsv_pkg::SAT_FRAC_BITS_DEF,
  localparam int HUE_SIXTY    = hsv_pkg::HUE_DEG_SEXTANT << HUE_FRAC_BITS,
  localparam int HUE_FULL     = hsv_pkg::HUE_DEG_FULL << HUE_FRAC_BITS,
  localparam int QH           = $clog2(HUE_SIXTY + 1),
  localparam int HB           = $clog2(HUE_FULL),
  localparam int DH           = QH + PIXEL_BITS,
  localparam int DS           = PIXEL_BITS + SAT_FRAC_BITS
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      up_valid,
  output logic                     up_ready,
  input  wire hsv_pkg::pix_in_t    up_data,
  output logic                     dn_valid,
  input  wire                      dn_ready,
  output logic [PIXEL_BITS-1:0]    mx_o,
  output logic [PIXEL_BITS-1:0]    delta_o,
  output logic [HB-1:0]            base_o,
  output logic [DH-1:0]            rem_h_o,
  output logic [DS-1:0]            rem_s_o
);

  localparam int P = PIXEL_BITS;
  localparam int CW = hsv_pkg::CHAN_W;

  // Sextant index that sets the hue base (times HUE_SIXTY)
  localparam logic [2:0] SEXT_RED_POS = 3'd0;
  localparam logic [2:0] SEXT_GRN_NEG = 3'd1;
  localparam logic [2:0] SEXT_GRN_POS = 3'd2;
  localparam logic [2:0] SEXT_BLU_NEG = 3'd3;
  localparam logic [2:0] SEXT_BLU_POS = 3'd4;
  localparam logic [2:0] SEXT_RED_NEG = 3'd5;

  logic [P+CW-1:0] r_ext, g_ext, b_ext;
  logic [P-1:0]    r, g, b, mx, mn, delta, frac;
  logic signed [P:0] diff;
  logic [2:0]      sext;
  logic            neg;

  logic            valid_r;
  logic [P-1:0]    mx_r, delta_r;
  logic [HB-1:0]   base_r, base_nxt;
  logic [DH-1:0]   rem_h_r, rem_h_nxt;
  logic [DS-1:0]   rem_s_r, rem_s_nxt;

  // Mask or widen each channel to the working pixel width
  assign r_ext = {{P{1'b0}}, up_data.red_in};
  assign g_ext = {{P{1'b0}}, up_data.green_in};
  assign b_ext = {{P{1'b0}}, up_data.blue_in};
  assign r = r_ext[P-1:0];
  assign g = g_ext[P-1:0];
  assign b = b_ext[P-1:0];

  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
  end

  // Red wins ties, then green; a negative diff folds into the sextant below
  always_comb begin
    if (r == mx) begin
      diff = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (g == mx) begin
      diff = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      diff = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    neg = diff[P];
    if (r == mx) begin
      sext = neg ? SEXT_RED_NEG : SEXT_RED_POS;
    end else if (g == mx) begin
      sext = neg ? SEXT_GRN_NEG : SEXT_GRN_POS;
    end else begin
      sext = neg ? SEXT_BLU_NEG : SEXT_BLU_POS;
    end
    frac = neg ? (delta + diff[P-1:0]) : diff[P-1:0];
  end

  assign base_nxt  = HB'(sext) * HB'(HUE_SIXTY);
  assign rem_h_nxt = DH'(frac) * DH'(HUE_SIXTY);
  assign rem_s_nxt = DS'(delta) << SAT_FRAC_BITS;

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      mx_r    <= mx;
      delta_r <= delta;
      base_r  <= base_nxt;
      rem_h_r <= rem_h_nxt;
      rem_s_r <= rem_s_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign mx_o     = mx_r;
  assign delta_o  = delta_r;
  assign base_o   = base_r;
  assign rem_h_o  = rem_h_r;
  assign rem_s_o  = rem_s_r;

endmodule

`default_nettype wire

/* rtl/core/hsv_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module hsv_div_cell #(
  parameter int PIXEL_BITS    = hsv_pkg::PIXEL_BITS_DEF,
  parameter int HUE_FRAC_BITS = hsv_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = hsv_pkg::SAT_FRAC_BITS_DEF,
  parameter int STEP          = 0,
  localparam int HUE_SIXTY    = hsv_pkg::HUE_DEG_SEXTANT << HUE_FRAC_BITS,
  localparam int HUE_FULL     = hsv_pkg::HUE_DEG_FULL << HUE_FRAC_BITS,
  localparam int QH           = $clog2(HUE_SIXTY + 1),
  localparam int QS           = SAT_FRAC_BITS + 1,
  localparam int HB           = $clog2(HUE_FULL),
  localparam int DH           = QH + PIXEL_BITS,
  localparam int DS           = PIXEL_BITS + SAT_FRAC_BITS
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   up_valid,
  output logic                  up_ready,
  input  wire [PIXEL_BITS-1:0]  mx_i,
  input  wire [PIXEL_BITS-1:0]  delta_i,
  input  wire [HB-1:0]          base_i,
  input  wire [DH-1:0]          rem_h_i,
  input  wire [DS-1:0]          rem_s_i,
  input  wire [QH-1:0]          q_h_i,
  input  wire [QS-1:0]          q_s_i,
  output logic                  dn_valid,
  input  wire                   dn_ready,
  output logic [PIXEL_BITS-1:0] mx_o,
  output logic [PIXEL_BITS-1:0] delta_o,
  output logic [HB-1:0]         base_o,
  output logic [DH-1:0]         rem_h_o,
  output logic [DS-1:0]         rem_s_o,
  output logic [QH-1:0]         q_h_o,
  output logic [QS-1:0]         q_s_o
);

  logic                  valid_r;
  logic [PIXEL_BITS-1:0] mx_r, delta_r;
  logic [HB-1:0]         base_r;
  logic [DH-1:0]         rem_h_r, rem_h_nxt;
  logic [DS-1:0]         rem_s_r, rem_s_nxt;
  logic [QH-1:0]         q_h_r, q_h_nxt;
  logic [QS-1:0]         q_s_r, q_s_nxt;

  // One restoring step of the hue quotient: bit QH-1-STEP
  if (STEP < QH) begin : g_hue
    logic [DH-1:0] dvs_h;
    logic          ge_h;
    assign dvs_h     = DH'(delta_i) << (QH - 1 - STEP);
    assign ge_h      = rem_h_i >= dvs_h;
    assign rem_h_nxt = ge_h ? (rem_h_i - dvs_h) : rem_h_i;
    assign q_h_nxt   = {q_h_i[QH-2:0], ge_h};
  end else begin : g_hue_hold
    assign rem_h_nxt = rem_h_i;
    assign q_h_nxt   = q_h_i;
  end

  // One restoring step of the saturation quotient: bit QS-1-STEP
  if (STEP < QS) begin : g_sat
    logic [DS-1:0] dvs_s;
    logic          ge_s;
    assign dvs_s     = DS'(mx_i) << (QS - 1 - STEP);
    assign ge_s      = rem_s_i >= dvs_s;
    assign rem_s_nxt = ge_s ? (rem_s_i - dvs_s) : rem_s_i;
    assign q_s_nxt   = {q_s_i[QS-2:0], ge_s};
  end else begin : g_sat_hold
    assign rem_s_nxt = rem_s_i;
    assign q_s_nxt   = q_s_i;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      mx_r    <= mx_i;
      delta_r <= delta_i;
      base_r  <= base_i;
      rem_h_r <= rem_h_nxt;
      rem_s_r <= rem_s_nxt;
      q_h_r   <= q_h_nxt;
      q_s_r   <= q_s_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign mx_o     = mx_r;
  assign delta_o  = delta_r;
  assign base_o   = base_r;
  assign rem_h_o  = rem_h_r;
  assign rem_s_o  = rem_s_r;
  assign q_h_o    = q_h_r;
  assign q_s_o    = q_s_r;

endmodule

`default_nettype wire

/* rtl/core/rgb_to_hsv_pixel_top.sv */
// RGB to HSV pixel converter.
// Pipeline: the front stage, a chain of division cells, and the output register.
// Throughput: one pixel word per cycle while out_ready allows, set by one quotient bit per cell in the chain.
// Reset: rst_n is synchronous, active low, and drops every word in flight.
// No state is kept between pixels.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_pixel_top #(
  parameter int PIXEL_BITS    = hsv_pkg::PIXEL_BITS_DEF,
  parameter int HUE_FRAC_BITS = hsv_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = hsv_pkg::SAT_FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire hsv_pkg::pix_in_t in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output hsv_pkg::hsv_out_t    out_data
);

  // Working widths. The hue quotient is the fraction of one sextant and
  // never exceeds HUE_SIXTY; the saturation quotient never exceeds 2^S.
  localparam int P         = PIXEL_BITS;
  localparam int HUE_SIXTY = hsv_pkg::HUE_DEG_SEXTANT << HUE_FRAC_BITS;
  localparam int HUE_FULL  = hsv_pkg::HUE_DEG_FULL << HUE_FRAC_BITS;
  localparam int QH        = $clog2(HUE_SIXTY + 1);
  localparam int QS        = SAT_FRAC_BITS + 1;
  localparam int HB        = $clog2(HUE_FULL);
  localparam int DH        = QH + P;
  localparam int DS        = P + SAT_FRAC_BITS;
  localparam int NCELL     = (QH > QS) ? QH : QS;

  localparam int HUE_W = hsv_pkg::HUE_W;
  localparam int SAT_W = hsv_pkg::SAT_W;
  localparam int VAL_W = hsv_pkg::VAL_W;

  // Links between stages: index k feeds cell k, index NCELL feeds the output register
  logic            vld_c   [0:NCELL];
  logic            rdy_c   [0:NCELL];
  logic [P-1:0]    mx_c    [0:NCELL];
  logic [P-1:0]    delta_c [0:NCELL];
  logic [HB-1:0]   base_c  [0:NCELL];
  logic [DH-1:0]   rem_h_c [0:NCELL];
  logic [DS-1:0]   rem_s_c [0:NCELL];
  logic [QH-1:0]   q_h_c   [0:NCELL];
  logic [QS-1:0]   q_s_c   [0:NCELL];

  // Front stage: find max, min, sextant, and load both dividends
  hsv_prep #(
    .PIXEL_BITS    (PIXEL_BITS),
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .SAT_FRAC_BITS (SAT_FRAC_BITS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (vld_c[0]),
    .dn_ready (rdy_c[0]),
    .mx_o     (mx_c[0]),
    .delta_o  (delta_c[0]),
    .base_o   (base_c[0]),
    .rem_h_o  (rem_h_c[0]),
    .rem_s_o  (rem_s_c[0])
  );

  // Quotients start empty; each cell shifts in one bit of each quotient that still has bits to resolve
  assign q_h_c[0] = '0;
  assign q_s_c[0] = '0;

  // Chain of division cells; each stage holds its own word and advances
  // whenever the stage ahead is empty or moving, so bubbles close up.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    hsv_div_cell #(
      .PIXEL_BITS    (PIXEL_BITS),
      .HUE_FRAC_BITS (HUE_FRAC_BITS),
      .SAT_FRAC_BITS (SAT_FRAC_BITS),
      .STEP          (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld_c[k]),
      .up_ready (rdy_c[k]),
      .mx_i     (mx_c[k]),
      .delta_i  (delta_c[k]),
      .base_i   (base_c[k]),
      .rem_h_i  (rem_h_c[k]),
      .rem_s_i  (rem_s_c[k]),
      .q_h_i    (q_h_c[k]),
      .q_s_i    (q_s_c[k]),
      .dn_valid (vld_c[k+1]),
      .dn_ready (rdy_c[k+1]),
      .mx_o     (mx_c[k+1]),
      .delta_o  (delta_c[k+1]),
      .base_o   (base_c[k+1]),
      .rem_h_o  (rem_h_c[k+1]),
      .rem_s_o  (rem_s_c[k+1]),
      .q_h_o    (q_h_c[k+1]),
      .q_s_o    (q_s_c[k+1])
    );
  end

  // Output register: add the sextant base and apply the achromatic rules.
  // A black pixel forces saturation to zero; zero spread or zero saturation
  // forces hue to zero.
  logic [P-1:0]        mx_f, delta_f;
  logic [QS-1:0]       sat_f;
  logic [HB-1:0]       hue_f;
  logic [HB+HUE_W-1:0] hue_ext;
  logic [QS+SAT_W-1:0] sat_ext;
  logic [P+VAL_W-1:0]  val_ext;
  logic                out_valid_r;
  hsv_pkg::hsv_out_t   out_data_r, out_data_nxt;

  assign mx_f    = mx_c[NCELL];
  assign delta_f = delta_c[NCELL];
  assign sat_f   = (mx_f == '0) ? '0 : q_s_c[NCELL];
  assign hue_f   = ((delta_f == '0) || (sat_f == '0)) ? '0
                 : (base_c[NCELL] + HB'(q_h_c[NCELL]));

  // Fit the working widths to the port fields
  assign hue_ext = {{HUE_W{1'b0}}, hue_f};
  assign sat_ext = {{SAT_W{1'b0}}, sat_f};
  assign val_ext = {{VAL_W{1'b0}}, mx_f};

  always_comb begin
    out_data_nxt.hue_out = hue_ext[HUE_W-1:0];
    out_data_nxt.sat_out = sat_ext[SAT_W-1:0];
    out_data_nxt.val_out = val_ext[VAL_W-1:0];
  end

  // Hold the result until taken; accept a new word when empty or draining
  assign rdy_c[NCELL] = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_c[NCELL]) begin
      out_valid_r <= vld_c[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c[NCELL] && vld_c[NCELL]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
